[rtl/core/atsg_pkg.sv]
// Shared constants and types for the alert tone sample generator.
package atsg_pkg;

    // Audio timing
    localparam int SAMPLE_RATE    = 48000;
    localparam int PATTERN_FRAMES = 9600;
    localparam int RAMP_FRAMES    = 160;

    // Level scaling
    localparam int PEAK_LEVEL = 24000;
    localparam int TRI_TOP    = 32767;
    localparam int VOL_MAX    = 100;

    // Tone layout inside one pattern period
    localparam int ALARM_LEN   = 4800;
    localparam int TIMER_LEN   = 2400;
    localparam int TIMER2_BASE = 3200;
    localparam int BEEP_LEN    = 1200;
    localparam int BEEP2_BASE  = 2400;
    localparam int FREQ_LOW    = 660;
    localparam int FREQ_MID    = 880;
    localparam int FREQ_HIGH   = 1047;

    // mod SAMPLE_RATE: low 7 bits pass, the rest is reduced mod the odd factor
    localparam int RATE_ODD = SAMPLE_RATE / 128;
    localparam int FOLD16   = 65536 % RATE_ODD;
    localparam int RECIP24  = (1 << 24) / RATE_ODD;

    // Triangle slope: phase*(2*TRI_TOP)/(SAMPLE_RATE/2) == phase*TRI_TOP/TRI_DIV
    localparam int HALF_RATE = SAMPLE_RATE / 2;
    localparam int TRI_DIV   = HALF_RATE / 2;
    localparam longint RECIP44 = (longint'(1) << 44) / TRI_DIV;

    // Final divide by TRI_TOP*VOL_MAX*RAMP_FRAMES, with the factor 128 taken as a shift
    localparam int OUT_DIV = (TRI_TOP * VOL_MAX * RAMP_FRAMES) / 128;
    localparam longint RECIP40 = (longint'(1) << 40) / OUT_DIV;

    // Pipeline depth (stage 0 is the entry register, the last is the output register)
    localparam int NST = 18;

    // Configuration register indexes
    localparam logic CFG_TONE_PATTERN   = 1'b0;
    localparam logic CFG_VOLUME_PERCENT = 1'b1;

    typedef enum logic [1:0] {
        PAT_ALARM    = 2'd0,
        PAT_TIMER    = 2'd1,
        PAT_INTERVAL = 2'd2,
        PAT_INVALID  = 2'd3
    } pattern_t;

endpackage

[rtl/core/alert_tone_sample_generator.sv]
// Alert tone sample generator: frame number in, one triangle-wave sample out.
// The pipeline has 18 register stages, from the entry register (stage 0) to the output register.
// Throughput: one transaction per cycle while m_ready is high; each stage holds only while the stage
// after it is full and stalled, so bubbles collapse and no item is lost.
// Reset (aresetn low, synchronous): pipeline emptied, pattern = alarm, volume = 100.
// Configuration writes take effect on the next cycle.
module alert_tone_sample_generator (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [6:0]         cfg_wr_data,
    // frame input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [39:0]        s_absolute_frame,
    // sample output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_value,
    output logic               m_pattern_invalid
);

    localparam int LAST = atsg_pkg::NST - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    atsg_pkg::pattern_t pattern_reg;
    logic [21:0]        vol_scale_reg;   // PEAK_LEVEL * clamped volume
    logic [6:0]         vol_clamp;
    logic [21:0]        vol_scale_next;

    assign vol_clamp = (cfg_wr_data > 7'(atsg_pkg::VOL_MAX)) ?
                       7'(atsg_pkg::VOL_MAX) : cfg_wr_data;
    assign vol_scale_next = 22'(vol_clamp) * 22'(atsg_pkg::PEAK_LEVEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg   <= atsg_pkg::PAT_ALARM;
            vol_scale_reg <= 22'(atsg_pkg::VOL_MAX * atsg_pkg::PEAK_LEVEL);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                atsg_pkg::CFG_TONE_PATTERN:   pattern_reg <= atsg_pkg::pattern_t'(cfg_wr_data[1:0]);
                atsg_pkg::CFG_VOLUME_PERCENT: vol_scale_reg <= vol_scale_next;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [LAST:0] vld_reg;
    logic [LAST:0] en;

    always_comb begin
        en[LAST] = ~vld_reg[LAST] | m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i <= LAST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[LAST];

    // ------------------------------------------------------------------
    // Stage 0: first fold of frame>>7 modulo RATE_ODD
    // ------------------------------------------------------------------
    logic [25:0] t1_reg, t1_next;
    logic [6:0]  lo0_reg;

    assign t1_next = 26'(s_absolute_frame[39:23]) * 26'(atsg_pkg::FOLD16)
                   + 26'(s_absolute_frame[22:7]);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t1_reg  <= t1_next;
            lo0_reg <= s_absolute_frame[6:0];
        end
    end

    // Stage 1: two more folds down to 17 bits
    logic [17:0] t2;
    logic [16:0] t3_reg, t3_next;
    logic [6:0]  lo1_reg;

    assign t2      = 18'(t1_reg[25:16]) * 18'(atsg_pkg::FOLD16) + 18'(t1_reg[15:0]);
    assign t3_next = 17'(t2[17:16]) * 17'(atsg_pkg::FOLD16) + 17'(t2[15:0]);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            t3_reg  <= t3_next;
            lo1_reg <= lo0_reg;
        end
    end

    // Stage 2: reciprocal quotient estimate
    logic [32:0] q2_prod;
    logic [8:0]  q2_reg;
    logic [16:0] t3b_reg;
    logic [6:0]  lo2_reg;

    assign q2_prod = 33'(t3_reg) * 33'(atsg_pkg::RECIP24);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            q2_reg  <= q2_prod[32:24];
            t3b_reg <= t3_reg;
            lo2_reg <= lo1_reg;
        end
    end

    // Stage 3: remainder with one correction -> frame mod SAMPLE_RATE
    logic [16:0] r3_raw, r3;
    logic [15:0] fm3_reg, fm3_next;

    assign r3_raw = t3b_reg - 17'(q2_reg) * 17'(atsg_pkg::RATE_ODD);
    assign r3     = (r3_raw >= 17'(atsg_pkg::RATE_ODD)) ?
                    r3_raw - 17'(atsg_pkg::RATE_ODD) : r3_raw;
    assign fm3_next = {r3[8:0], lo2_reg};

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            fm3_reg <= fm3_next;
        end
    end

    // Stage 4: position inside the pattern period
    logic [15:0] pf_wide;
    logic [13:0] pf4_reg;
    logic [15:0] fm4_reg;

    always_comb begin
        if (fm3_reg >= 16'(4 * atsg_pkg::PATTERN_FRAMES)) begin
            pf_wide = fm3_reg - 16'(4 * atsg_pkg::PATTERN_FRAMES);
        end else if (fm3_reg >= 16'(3 * atsg_pkg::PATTERN_FRAMES)) begin
            pf_wide = fm3_reg - 16'(3 * atsg_pkg::PATTERN_FRAMES);
        end else if (fm3_reg >= 16'(2 * atsg_pkg::PATTERN_FRAMES)) begin
            pf_wide = fm3_reg - 16'(2 * atsg_pkg::PATTERN_FRAMES);
        end else if (fm3_reg >= 16'(atsg_pkg::PATTERN_FRAMES)) begin
            pf_wide = fm3_reg - 16'(atsg_pkg::PATTERN_FRAMES);
        end else begin
            pf_wide = fm3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            pf4_reg <= pf_wide[13:0];
            fm4_reg <= fm3_reg;
        end
    end

    // Stage 5: tone lookup for the selected pattern
    logic        in_tone;
    logic [13:0] pos_w, left_w;
    logic [10:0] freq_w;
    logic        in5_reg, inval5_reg;
    logic [12:0] pos5_reg, left5_reg;
    logic [10:0] freq5_reg;
    logic [15:0] fm5_reg;

    always_comb begin
        in_tone = 1'b0;
        pos_w   = pf4_reg;
        left_w  = '0;
        freq_w  = 11'(atsg_pkg::FREQ_MID);
        case (pattern_reg)
            atsg_pkg::PAT_ALARM: begin
                if (pf4_reg < 14'(atsg_pkg::ALARM_LEN)) begin
                    in_tone = 1'b1;
                    left_w  = 14'(atsg_pkg::ALARM_LEN - 1) - pf4_reg;
                end
            end
            atsg_pkg::PAT_TIMER: begin
                if (pf4_reg < 14'(atsg_pkg::TIMER_LEN)) begin
                    in_tone = 1'b1;
                    left_w  = 14'(atsg_pkg::TIMER_LEN - 1) - pf4_reg;
                    freq_w  = 11'(atsg_pkg::FREQ_LOW);
                end else if (pf4_reg >= 14'(atsg_pkg::TIMER2_BASE) &&
                             pf4_reg < 14'(atsg_pkg::TIMER2_BASE + atsg_pkg::TIMER_LEN)) begin
                    in_tone = 1'b1;
                    pos_w   = pf4_reg - 14'(atsg_pkg::TIMER2_BASE);
                    left_w  = 14'(atsg_pkg::TIMER2_BASE + atsg_pkg::TIMER_LEN - 1) - pf4_reg;
                end
            end
            atsg_pkg::PAT_INTERVAL: begin
                freq_w = 11'(atsg_pkg::FREQ_HIGH);
                if (pf4_reg < 14'(atsg_pkg::BEEP_LEN)) begin
                    in_tone = 1'b1;
                    left_w  = 14'(atsg_pkg::BEEP_LEN - 1) - pf4_reg;
                end else if (pf4_reg >= 14'(atsg_pkg::BEEP2_BASE) &&
                             pf4_reg < 14'(atsg_pkg::BEEP2_BASE + atsg_pkg::BEEP_LEN)) begin
                    in_tone = 1'b1;
                    pos_w   = pf4_reg - 14'(atsg_pkg::BEEP2_BASE);
                    left_w  = 14'(atsg_pkg::BEEP2_BASE + atsg_pkg::BEEP_LEN - 1) - pf4_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            in5_reg    <= in_tone;
            inval5_reg <= (pattern_reg == atsg_pkg::PAT_INVALID);
            pos5_reg   <= pos_w[12:0];
            left5_reg  <= left_w[12:0];
            freq5_reg  <= freq_w;
            fm5_reg    <= fm4_reg;
        end
    end

    // Stage 6: phase product and envelope gain
    logic [25:0] prod6_next;
    logic [7:0]  rise, fall, gain6_next;
    logic [25:0] prod6_reg;
    logic [7:0]  gain6_reg;
    logic        zero6_reg, inval6_reg;

    assign prod6_next = 26'(fm5_reg) * 26'(freq5_reg);
    assign rise = (pos5_reg > 13'(atsg_pkg::RAMP_FRAMES)) ?
                  8'(atsg_pkg::RAMP_FRAMES) : pos5_reg[7:0];
    assign fall = (left5_reg > 13'(atsg_pkg::RAMP_FRAMES)) ?
                  8'(atsg_pkg::RAMP_FRAMES) : left5_reg[7:0];
    assign gain6_next = (rise < fall) ? rise : fall;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            prod6_reg  <= prod6_next;
            gain6_reg  <= gain6_next;
            zero6_reg  <= ~in5_reg;
            inval6_reg <= inval5_reg;
        end
    end

    // Stage 7: quotient estimate for product mod SAMPLE_RATE
    logic [34:0] q7_prod;
    logic [10:0] q7_reg;
    logic [18:0] x7_reg;
    logic [6:0]  lo7_reg;
    logic [7:0]  gain7_reg;
    logic        zero7_reg, inval7_reg;

    assign q7_prod = 35'(prod6_reg[25:7]) * 35'(atsg_pkg::RECIP24);

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            q7_reg     <= q7_prod[34:24];
            x7_reg     <= prod6_reg[25:7];
            lo7_reg    <= prod6_reg[6:0];
            gain7_reg  <= gain6_reg;
            zero7_reg  <= zero6_reg;
            inval7_reg <= inval6_reg;
        end
    end

    // Stage 8: phase = remainder with one correction
    logic [18:0] r8_raw, r8;
    logic [15:0] phase8_reg;
    logic [7:0]  gain8_reg;
    logic        zero8_reg, inval8_reg;

    assign r8_raw = x7_reg - 19'(q7_reg) * 19'(atsg_pkg::RATE_ODD);
    assign r8     = (r8_raw >= 19'(atsg_pkg::RATE_ODD)) ?
                    r8_raw - 19'(atsg_pkg::RATE_ODD) : r8_raw;

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            phase8_reg <= {r8[8:0], lo7_reg};
            gain8_reg  <= gain7_reg;
            zero8_reg  <= zero7_reg;
            inval8_reg <= inval7_reg;
        end
    end

    // Stage 9: triangle half select and slope numerator
    logic        dir9_next;
    logic [15:0] d9;
    logic [29:0] n9_reg;
    logic        dir9_reg;
    logic [7:0]  gain9_reg;
    logic        zero9_reg, inval9_reg;

    assign dir9_next = (phase8_reg >= 16'(atsg_pkg::HALF_RATE));
    assign d9 = dir9_next ? phase8_reg - 16'(atsg_pkg::HALF_RATE) : phase8_reg;

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            n9_reg     <= 30'(d9[14:0]) * 30'(atsg_pkg::TRI_TOP);
            dir9_reg   <= dir9_next;
            gain9_reg  <= gain8_reg;
            zero9_reg  <= zero8_reg;
            inval9_reg <= inval8_reg;
        end
    end

    // Stage 10: slope quotient estimate (divide by TRI_DIV)
    logic [60:0] q10_prod;
    logic [15:0] q10_reg;
    logic [29:0] n10_reg;
    logic        dir10_reg;
    logic [7:0]  gain10_reg;
    logic        zero10_reg, inval10_reg;

    assign q10_prod = 61'(n9_reg) * 61'(atsg_pkg::RECIP44);

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            q10_reg     <= q10_prod[59:44];
            n10_reg     <= n9_reg;
            dir10_reg   <= dir9_reg;
            gain10_reg  <= gain9_reg;
            zero10_reg  <= zero9_reg;
            inval10_reg <= inval9_reg;
        end
    end

    // Stage 11: quotient correction and triangle value
    logic [29:0] rem11;
    logic [15:0] qt11;
    logic [16:0] tri17;
    logic signed [15:0] tri11_reg;
    logic [7:0]  gain11_reg;
    logic        zero11_reg, inval11_reg;

    assign rem11 = n10_reg - 30'(q10_reg) * 30'(atsg_pkg::TRI_DIV);
    assign qt11  = (rem11 >= 30'(atsg_pkg::TRI_DIV)) ? q10_reg + 16'd1 : q10_reg;
    assign tri17 = dir10_reg ? 17'(atsg_pkg::TRI_TOP) - {1'b0, qt11}
                             : {1'b0, qt11} - 17'(atsg_pkg::TRI_TOP);

    always_ff @(posedge aclk) begin
        if (en[11]) begin
            tri11_reg   <= tri17[15:0];
            gain11_reg  <= gain10_reg;
            zero11_reg  <= zero10_reg;
            inval11_reg <= inval10_reg;
        end
    end

    // Stage 12: scale by peak level and volume
    logic signed [37:0] acc12_reg;
    logic [7:0]  gain12_reg;
    logic        zero12_reg, inval12_reg;

    always_ff @(posedge aclk) begin
        if (en[12]) begin
            acc12_reg   <= 38'(tri11_reg) * 38'($signed({1'b0, vol_scale_reg}));
            gain12_reg  <= gain11_reg;
            zero12_reg  <= zero11_reg;
            inval12_reg <= inval11_reg;
        end
    end

    // Stage 13: scale by envelope gain
    logic signed [45:0] acc13_reg;
    logic        zero13_reg, inval13_reg;

    always_ff @(posedge aclk) begin
        if (en[13]) begin
            acc13_reg   <= 46'(acc12_reg) * 46'($signed({1'b0, gain12_reg}));
            zero13_reg  <= zero12_reg;
            inval13_reg <= inval12_reg;
        end
    end

    // Stage 14: magnitude, with the power-of-two part of the divisor shifted out
    logic [45:0] mag14;
    logic [36:0] m14_reg;
    logic        neg14_reg, zero14_reg, inval14_reg;

    assign mag14 = acc13_reg[45] ? 46'(-acc13_reg) : 46'(acc13_reg);

    always_ff @(posedge aclk) begin
        if (en[14]) begin
            m14_reg     <= mag14[43:7];
            neg14_reg   <= acc13_reg[45];
            zero14_reg  <= zero13_reg;
            inval14_reg <= inval13_reg;
        end
    end

    // Stage 15: reciprocal partial products
    logic [36:0] pph15_reg;
    logic [37:0] ppl15_reg;
    logic [36:0] m15_reg;
    logic        neg15_reg, zero15_reg, inval15_reg;

    always_ff @(posedge aclk) begin
        if (en[15]) begin
            pph15_reg   <= 37'(m14_reg[36:19]) * 37'(atsg_pkg::RECIP40);
            ppl15_reg   <= 38'(m14_reg[18:0]) * 38'(atsg_pkg::RECIP40);
            m15_reg     <= m14_reg;
            neg15_reg   <= neg14_reg;
            zero15_reg  <= zero14_reg;
            inval15_reg <= inval14_reg;
        end
    end

    // Stage 16: combine partial products into the quotient estimate
    logic [56:0] sum16;
    logic [14:0] q16_reg;
    logic [36:0] m16_reg;
    logic        neg16_reg, zero16_reg, inval16_reg;

    assign sum16 = {1'b0, pph15_reg, 19'd0} + 57'(ppl15_reg);

    always_ff @(posedge aclk) begin
        if (en[16]) begin
            q16_reg     <= sum16[54:40];
            m16_reg     <= m15_reg;
            neg16_reg   <= neg15_reg;
            zero16_reg  <= zero15_reg;
            inval16_reg <= inval15_reg;
        end
    end

    // Stage 17: correction, sign and output register
    logic [36:0] rem17;
    logic [14:0] qf17;
    logic signed [15:0] smp17;
    logic signed [15:0] sample_reg;
    logic        invalid_reg;

    assign rem17 = m16_reg - 37'(q16_reg) * 37'(atsg_pkg::OUT_DIV);
    assign qf17  = (rem17 >= 37'(atsg_pkg::OUT_DIV)) ? q16_reg + 15'd1 : q16_reg;

    always_comb begin
        if (zero16_reg) begin
            smp17 = '0;
        end else if (neg16_reg) begin
            smp17 = -$signed({1'b0, qf17});
        end else begin
            smp17 = $signed({1'b0, qf17});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[17]) begin
            sample_reg  <= smp17;
            invalid_reg <= inval16_reg;
        end
    end

    assign m_sample_value    = sample_reg;
    assign m_pattern_invalid = invalid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_invalid_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pattern_invalid |-> m_sample_value == 16'sd0)
        else $error("invalid pattern produced a nonzero sample");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_value <= 16'sd24000) && (m_sample_value >= -16'sd24000))
        else $error("sample outside peak level");

    a_ready_when_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[LAST] |-> s_ready)
        else $error("input stalled with an empty output register");

endmodule
